// ===== hw/rtl/ebm_pkg.sv =====
// Shared constants and command codes for the erase block map and state table.
// Used by the top level, the scan unit and the testbench; depends on nothing.
package ebm_pkg;

    localparam int MAX_LOGICAL_BLOCKS  = 1024;
    localparam int MAX_PHYSICAL_BLOCKS = 1024;

    localparam int LOG_IDX_W  = $clog2(MAX_LOGICAL_BLOCKS);
    localparam int PHYS_IDX_W = $clog2(MAX_PHYSICAL_BLOCKS);
    localparam int BLK_W      = 11;
    localparam int CNT_W      = 11;
    localparam int CMD_W      = 3;

    // state store is organized as rows of lanes, scanned one row per cycle
    localparam int SCAN_LANES = 64;
    localparam int LANE_W     = $clog2(SCAN_LANES);
    localparam int STATE_ROWS = MAX_PHYSICAL_BLOCKS / SCAN_LANES;
    localparam int ROW_W      = $clog2(STATE_ROWS);
    localparam int ST_W       = 2;
    localparam int ROW_BITS   = SCAN_LANES * ST_W;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_LOGICAL  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHYSICAL = 1'b1;

    localparam logic [CMD_W-1:0] CMD_READ_MAP   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE_MAP  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY_FREE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_MARK_FREE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_MARK_USED  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_MARK_BAD   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_FIND_FREE  = 3'd6;

    localparam logic [ST_W-1:0] ST_FREE = 2'd0;
    localparam logic [ST_W-1:0] ST_USED = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD  = 2'd2;

    localparam logic [BLK_W-1:0] BLK_NONE = {BLK_W{1'b1}};

    localparam logic [CNT_W-1:0] LOGICAL_CAP  = CNT_W'(MAX_LOGICAL_BLOCKS);
    localparam logic [CNT_W-1:0] PHYSICAL_CAP = CNT_W'(MAX_PHYSICAL_BLOCKS);

endpackage

// ===== hw/rtl/erase_block_map_and_state_table.sv =====
// Top level of the erase block map and state table: sequencer, map RAM,
// row-organized state RAM and the row scan unit. Depends on ebm_pkg,
// ebm_ram and ebm_scan.
//
// Usage:
//   The s_ channel takes one command per transfer; the m_ channel returns
//   exactly one result per command, in order. The cfg channel writes the
//   logical and physical block counts (index 0 and 1); the user writes them
//   only while the block idles, which the block itself does not enforce.
//   Read map, query and mark pass through the execute, data and response
//   states before the result is registered; write map, range errors and the
//   unused code skip the data state. Find free reads the state store one row
//   of 64 blocks per cycle through the scan unit, and skips the scan when the
//   search limit is zero. s_tready returns in the same cycle that the result
//   becomes valid. A new command is taken when the sequencer is idle, even
//   while the previous result waits on m_tready. After reset the block sweeps
//   both stores, one entry per cycle (map to unmapped, states to free), with
//   s_tready low; cfg writes are taken throughout. If the receiver stalls, the
//   finished result holds in the output register and the next result waits in
//   the sequencer until the register drains.
module erase_block_map_and_state_table (
    input  logic                          aclk,
    input  logic                          aresetn,
    // s_tdata: command[2:0], logical_block[12:3], physical_block[23:13],
    //          search_limit[34:24], zero fill[39:35]
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ebm_pkg::S_TDATA_W-1:0] s_tdata,
    // m_tdata: block_result[10:0], is_free[11], range_error[12], zero fill[15:13]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ebm_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ebm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ebm_pkg::CNT_W-1:0]     cfg_data
);
    import ebm_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_EXEC  = 6'b000100,
        S_DATA  = 6'b001000,
        S_SCAN  = 6'b010000,
        S_RESP  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [LOG_IDX_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [CNT_W-1:0]     nlog_reg, nphys_reg;
    logic [CMD_W-1:0]     cmd_reg, cmd_next;
    logic [LOG_IDX_W-1:0] lidx_reg, lidx_next;
    logic [BLK_W-1:0]     pblk_reg, pblk_next;
    logic [CNT_W-1:0]     limit_reg, limit_next;
    logic [ROW_W-1:0]     last_row_reg, last_row_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic                 err_reg, err_next;
    logic [BLK_W-1:0]     res_blk_reg, res_blk_next;
    logic                 res_free_reg, res_free_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // input fields
    logic [CMD_W-1:0]     in_cmd;
    logic [LOG_IDX_W-1:0] in_lidx;
    logic [BLK_W-1:0]     in_pblk;
    logic [CNT_W-1:0]     in_limit;
    logic                 accept;

    logic [CNT_W-1:0] nlog_cap, nphys_cap, limit_cap, limit_m1;
    logic             lerr, perr;

    // memories
    logic                 map_we;
    logic [LOG_IDX_W-1:0] map_waddr, map_raddr;
    logic [BLK_W-1:0]     map_wdata, map_rdata;
    logic                 st_we;
    logic [ROW_W-1:0]     st_waddr, st_raddr;
    logic [ROW_BITS-1:0]  st_wdata, st_rdata;

    logic [ROW_W-1:0]  p_row;
    logic [LANE_W-1:0] p_lane;
    logic [ST_W-1:0]   mark_code;
    logic [ROW_BITS-1:0] row_mod;
    logic              scan_found;
    logic [LANE_W-1:0] scan_lane;

    assign in_cmd   = s_tdata[2:0];
    assign in_lidx  = s_tdata[12:3];
    assign in_pblk  = s_tdata[23:13];
    assign in_limit = s_tdata[34:24];

    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign nlog_cap  = (nlog_reg > LOGICAL_CAP) ? LOGICAL_CAP : nlog_reg;
    assign nphys_cap = (nphys_reg > PHYSICAL_CAP) ? PHYSICAL_CAP : nphys_reg;
    assign limit_cap = (in_limit > nphys_cap) ? nphys_cap : in_limit;
    assign limit_m1  = limit_cap - CNT_W'(1);

    assign lerr = ({1'b0, in_lidx} >= nlog_cap);
    assign perr = in_pblk[BLK_W-1] || ({1'b0, in_pblk[PHYS_IDX_W-1:0]} >= nphys_cap);

    assign p_row  = pblk_reg[PHYS_IDX_W-1:LANE_W];
    assign p_lane = pblk_reg[LANE_W-1:0];

    always_comb begin
        case (cmd_reg)
            CMD_MARK_USED: mark_code = ST_USED;
            CMD_MARK_BAD:  mark_code = ST_BAD;
            default:       mark_code = ST_FREE;
        endcase
    end

    always_comb begin
        row_mod = st_rdata;
        row_mod[p_lane*ST_W +: ST_W] = mark_code;
    end

    ebm_ram #(
        .WIDTH (BLK_W),
        .DEPTH (MAX_LOGICAL_BLOCKS)
    ) u_map_ram (
        .aclk    (aclk),
        .wr_en   (map_we),
        .wr_addr (map_waddr),
        .wr_data (map_wdata),
        .rd_addr (map_raddr),
        .rd_data (map_rdata)
    );

    ebm_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (STATE_ROWS)
    ) u_state_ram (
        .aclk    (aclk),
        .wr_en   (st_we),
        .wr_addr (st_waddr),
        .wr_data (st_wdata),
        .rd_addr (st_raddr),
        .rd_data (st_rdata)
    );

    ebm_scan u_scan (
        .row_data (st_rdata),
        .row      (row_reg),
        .limit    (limit_reg),
        .found    (scan_found),
        .lane     (scan_lane)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nlog_reg  <= LOGICAL_CAP;
            nphys_reg <= PHYSICAL_CAP;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_LOGICAL:  nlog_reg  <= cfg_data;
                CFG_PHYSICAL: nphys_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        cmd_next      = cmd_reg;
        lidx_next     = lidx_reg;
        pblk_next     = pblk_reg;
        limit_next    = limit_reg;
        last_row_next = last_row_reg;
        row_next      = row_reg;
        err_next      = err_reg;
        res_blk_next  = res_blk_reg;
        res_free_next = res_free_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        map_we    = 1'b0;
        map_waddr = lidx_reg;
        map_wdata = pblk_reg;
        map_raddr = lidx_reg;
        st_we     = 1'b0;
        st_waddr  = p_row;
        st_wdata  = row_mod;
        st_raddr  = p_row;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                map_we    = 1'b1;
                map_waddr = clr_cnt_reg;
                map_wdata = BLK_NONE;
                st_we     = 1'b1;
                st_waddr  = clr_cnt_reg[ROW_W-1:0];
                st_wdata  = '0;
                clr_cnt_next = clr_cnt_reg + LOG_IDX_W'(1);
                if (clr_cnt_reg == LOG_IDX_W'(MAX_LOGICAL_BLOCKS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    cmd_next      = in_cmd;
                    lidx_next     = in_lidx;
                    pblk_next     = in_pblk;
                    limit_next    = limit_cap;
                    last_row_next = limit_m1[LANE_W+ROW_W-1:LANE_W];
                    res_blk_next  = BLK_NONE;
                    res_free_next = 1'b0;
                    case (in_cmd) inside
                        CMD_READ_MAP, CMD_WRITE_MAP: err_next = lerr;
                        CMD_QUERY_FREE, CMD_MARK_FREE, CMD_MARK_USED,
                        CMD_MARK_BAD: err_next = perr;
                        default: err_next = 1'b0;
                    endcase
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                row_next = '0;
                if (cmd_reg == CMD_FIND_FREE) begin
                    st_raddr = '0;
                end
                if (err_reg) begin
                    state_next = S_RESP;
                end else begin
                    case (cmd_reg) inside
                        CMD_WRITE_MAP: begin
                            map_we     = 1'b1;
                            state_next = S_RESP;
                        end
                        CMD_READ_MAP, CMD_QUERY_FREE, CMD_MARK_FREE, CMD_MARK_USED,
                        CMD_MARK_BAD: state_next = S_DATA;
                        CMD_FIND_FREE: begin
                            state_next = (limit_reg == '0) ? S_RESP : S_SCAN;
                        end
                        default: state_next = S_RESP;
                    endcase
                end
            end
            S_DATA: begin
                case (cmd_reg) inside
                    CMD_READ_MAP:   res_blk_next = map_rdata;
                    CMD_QUERY_FREE: res_free_next = (st_rdata[p_lane*ST_W +: ST_W] == ST_FREE);
                    CMD_MARK_FREE, CMD_MARK_USED, CMD_MARK_BAD: st_we = 1'b1;
                    default: ;
                endcase
                state_next = S_RESP;
            end
            S_SCAN: begin
                // fetch the next row while this one is checked
                st_raddr = row_reg + ROW_W'(1);
                if (scan_found) begin
                    res_blk_next = {1'b0, row_reg, scan_lane};
                    state_next   = S_RESP;
                end else if (row_reg == last_row_reg) begin
                    state_next = S_RESP;
                end else begin
                    row_next = row_reg + ROW_W'(1);
                end
            end
            S_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'b000, err_reg, res_free_reg, res_blk_reg};
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        lidx_reg     <= lidx_next;
        pblk_reg     <= pblk_next;
        limit_reg    <= limit_next;
        last_row_reg <= last_row_next;
        row_reg      <= row_next;
        err_reg      <= err_next;
        res_blk_reg  <= res_blk_next;
        res_free_reg <= res_free_next;
        m_tdata_reg  <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // a new result only ever comes out of the response state
    a_result_from_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == S_RESP))
        else $error("result raised outside the response state");

    // a failed index check never carries a block number
    a_err_no_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[12]) |-> (m_tdata[10:0] == BLK_NONE && !m_tdata[11]))
        else $error("range error with a block or free flag");

    // no input transfer while the stores are being cleared
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> !s_tready)
        else $error("input taken during clearing sweep");

endmodule

// ===== hw/rtl/ebm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module ebm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/ebm_scan.sv =====
// Free-block search over one row of the state store.
// Depends on ebm_pkg.
module ebm_scan (
    input  logic [ebm_pkg::ROW_BITS-1:0] row_data,
    input  logic [ebm_pkg::ROW_W-1:0]    row,
    input  logic [ebm_pkg::CNT_W-1:0]    limit,
    output logic                         found,
    output logic [ebm_pkg::LANE_W-1:0]   lane
);
    import ebm_pkg::*;

    logic [SCAN_LANES-1:0] hit;

    // a lane counts when its block is free and lies below the search limit
    always_comb begin
        for (int i = 0; i < SCAN_LANES; i++) begin
            hit[i] = (row_data[i*ST_W +: ST_W] == ST_FREE) &&
                     ({1'b0, row, LANE_W'(i)} < limit);
        end
    end

    // lowest hit wins
    always_comb begin
        found = 1'b0;
        lane  = '0;
        for (int i = SCAN_LANES - 1; i >= 0; i--) begin
            if (hit[i]) begin
                found = 1'b1;
                lane  = LANE_W'(i);
            end
        end
    end

endmodule

// ===== tb/tb_erase_block_map_and_state_table.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for erase_block_map_and_state_table: a directed command table,
// then random command streams over several block counts, each result checked against
// an in-bench model of the map and state stores. Depends on ebm_pkg and the block's RTL.
module tb_erase_block_map_and_state_table;
    import ebm_pkg::*;

    localparam int CLK_PERIOD = 8;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

    typedef struct packed {
        logic [CMD_W-1:0]     cmd;
        logic [LOG_IDX_W-1:0] lblk;
        logic [BLK_W-1:0]     pblk;
        logic [CNT_W-1:0]     limit;
    } command_t;

    typedef struct packed {
        logic [BLK_W-1:0] blk;
        logic             is_free;
        logic             range_err;
    } result_t;

    typedef struct packed {
        command_t item;
        logic     typed;
        result_t  want;
    } dir_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CNT_W-1:0]     cfg_data;

    // model of the block's stores and counts
    logic [BLK_W-1:0] map_model   [MAX_LOGICAL_BLOCKS];
    logic [ST_W-1:0]  state_model [MAX_PHYSICAL_BLOCKS];
    logic [CNT_W-1:0] logical_count;
    logic [CNT_W-1:0] physical_count;

    result_t  pending_results [$];
    dir_row_t directed_rows [$];
    int       fail_count = 0;
    int       result_idx = 0;
    int       sweep_ptr = 0;
    bit       tx_idle;
    bit       rx_idle;
    int       rx_hold_cycles = 0;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    erase_block_map_and_state_table dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    function automatic int capped(logic [CNT_W-1:0] n, int top);
        return (int'(n) > top) ? top : int'(n);
    endfunction

    // Work out one command's result and update the model stores.
    function automatic result_t apply_command(command_t c);
        result_t r;
        int      nlog;
        int      nphys;
        int      lim;
        bit      phys_ok;
        bit      found;
        r.blk = BLK_NONE;
        r.is_free = 1'b0;
        r.range_err = 1'b0;
        nlog = capped(logical_count, MAX_LOGICAL_BLOCKS);
        nphys = capped(physical_count, MAX_PHYSICAL_BLOCKS);
        // a negative index never addresses a block
        phys_ok = !c.pblk[BLK_W-1] && (int'(c.pblk) < nphys);
        case (c.cmd)
            CMD_READ_MAP: begin
                if (int'(c.lblk) < nlog) r.blk = map_model[c.lblk];
                else r.range_err = 1'b1;
            end
            CMD_WRITE_MAP: begin
                if (int'(c.lblk) < nlog) map_model[c.lblk] = c.pblk;
                else r.range_err = 1'b1;
            end
            CMD_QUERY_FREE: begin
                if (phys_ok) r.is_free = (state_model[c.pblk[PHYS_IDX_W-1:0]] == ST_FREE);
                else r.range_err = 1'b1;
            end
            CMD_MARK_FREE, CMD_MARK_USED, CMD_MARK_BAD: begin
                if (!phys_ok)
                    r.range_err = 1'b1;
                else if (c.cmd == CMD_MARK_FREE)
                    state_model[c.pblk[PHYS_IDX_W-1:0]] = ST_FREE;
                else if (c.cmd == CMD_MARK_USED)
                    state_model[c.pblk[PHYS_IDX_W-1:0]] = ST_USED;
                else
                    state_model[c.pblk[PHYS_IDX_W-1:0]] = ST_BAD;
            end
            CMD_FIND_FREE: begin
                // the scan never runs past the physical count
                lim = capped(c.limit, nphys);
                found = 1'b0;
                for (int i = 0; i < lim && !found; i++) begin
                    if (state_model[i] == ST_FREE) begin
                        r.blk = BLK_W'(i);
                        found = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic int near_edge(int n);
        int lo;
        int hi;
        lo = (n > 0) ? n - 1 : 0;
        hi = (n + 1 > 1023) ? 1023 : n + 1;
        return $urandom_range(lo, hi);
    endfunction

    function automatic logic [LOG_IDX_W-1:0] pick_logical();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return LOG_IDX_W'($urandom_range(0, 31));
        if (r < 7) return LOG_IDX_W'(near_edge(capped(logical_count, MAX_LOGICAL_BLOCKS)));
        return LOG_IDX_W'($urandom_range(0, MAX_LOGICAL_BLOCKS - 1));
    endfunction

    function automatic logic [BLK_W-1:0] pick_physical();
        int r;
        int top;
        r = $urandom_range(0, 19);
        top = (sweep_ptr + 8 > 1023) ? 1023 : sweep_ptr + 8;
        if (r < 8) return BLK_W'($urandom_range(0, top));
        if (r < 11) return BLK_W'(near_edge(capped(physical_count, MAX_PHYSICAL_BLOCKS)));
        if (r < 13) return BLK_NONE;
        if (r < 14) return {1'b1, PHYS_IDX_W'($urandom)};
        return BLK_W'($urandom_range(0, MAX_PHYSICAL_BLOCKS - 1));
    endfunction

    function automatic logic [CNT_W-1:0] pick_limit();
        int r;
        int lo;
        int hi;
        r = $urandom_range(0, 9);
        lo = (sweep_ptr > 16) ? sweep_ptr - 16 : 0;
        hi = (sweep_ptr + 16 > 1024) ? 1024 : sweep_ptr + 16;
        if (r < 3) return PHYSICAL_CAP;
        if (r < 5) return CNT_W'($urandom_range(0, 4));
        if (r < 7) return CNT_W'($urandom_range(lo, hi));
        return CNT_W'($urandom_range(0, 1024));
    endfunction

    // In sweep mode most commands retire blocks in order from the sweep front, so
    // find free has to scan deep into the state store.
    function automatic command_t random_command(bit sweep);
        command_t c;
        int       r;
        c.lblk = pick_logical();
        c.pblk = pick_physical();
        c.limit = pick_limit();
        r = $urandom_range(0, 99);
        if (sweep && r < 60) begin
            c.cmd = (r < 50) ? CMD_MARK_USED : CMD_MARK_BAD;
            c.pblk = BLK_W'(sweep_ptr);
            if (sweep_ptr < MAX_PHYSICAL_BLOCKS - 1) sweep_ptr++;
        end else if (sweep && r < 63) begin
            // punch a hole behind the sweep front
            c.cmd = CMD_MARK_FREE;
            c.pblk = BLK_W'($urandom_range(0, sweep_ptr));
        end else if (sweep && r < 82) begin
            c.cmd = CMD_FIND_FREE;
        end else if (r < 97) begin
            c.cmd = CMD_W'($urandom_range(CMD_READ_MAP, CMD_FIND_FREE));
        end else begin
            c.cmd = CMD_UNUSED;
        end
        return c;
    endfunction

    task automatic note_fail(string msg);
        fail_count++;
        if (fail_count <= 10) $display("%s", msg);
    endtask

    task automatic add_row(logic [CMD_W-1:0] cmd, int lblk, logic [BLK_W-1:0] pblk, int limit,
                           bit typed, logic [BLK_W-1:0] blk, bit fr, bit er);
        dir_row_t row;
        row.item.cmd = cmd;
        row.item.lblk = LOG_IDX_W'(lblk);
        row.item.pblk = pblk;
        row.item.limit = CNT_W'(limit);
        row.typed = typed;
        row.want.blk = blk;
        row.want.is_free = fr;
        row.want.range_err = er;
        directed_rows.push_back(row);
    endtask

    // Offer one command; the model advances at the transfer.
    task automatic send_command(command_t c, bit typed, result_t want);
        int      gap;
        result_t predicted;
        gap = tx_idle ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({c.limit, c.pblk, c.lblk, c.cmd});
        do @(posedge aclk); while (!s_tready);
        predicted = apply_command(c);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic run_items(int count, bit sweep);
        for (int k = 0; k < count; k++)
            send_command(random_command(sweep), 1'b0, '0);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic set_block_counts(logic [CNT_W-1:0] nlog, logic [CNT_W-1:0] nphys);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_LOGICAL;
        cfg_data  <= nlog;
        do @(posedge aclk); while (!cfg_ready);
        logical_count = nlog;
        cfg_index <= CFG_PHYSICAL;
        cfg_data  <= nphys;
        do @(posedge aclk); while (!cfg_ready);
        physical_count = nphys;
        cfg_valid <= 1'b0;
    endtask

    task automatic check_result(logic [M_TDATA_W-1:0] data);
        result_t got;
        result_t want;
        got.blk = data[BLK_W-1:0];
        got.is_free = data[BLK_W];
        got.range_err = data[BLK_W+1];
        if (pending_results.size() == 0) begin
            note_fail($sformatf("unexpected result, m_tdata %h", data));
        end else begin
            want = pending_results.pop_front();
            if (got.blk !== want.blk || got.is_free !== want.is_free ||
                got.range_err !== want.range_err)
                note_fail($sformatf(
                    "result %0d: expected block %0d free %b error %b, got block %0d free %b error %b",
                    result_idx, $signed(want.blk), want.is_free, want.range_err,
                    $signed(got.blk), got.is_free, got.range_err));
            result_idx++;
        end
    endtask

    // result side: random stalls, plus a long hold-off when requested
    initial begin
        int gap;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (rx_hold_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge aclk);
                rx_hold_cycles = 0;
            end
            gap = rx_idle ? $urandom_range(0, 12) : 0;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            check_result(m_tdata);
        end
    end

    initial begin
        #2_000_000;
        $display("FAIL erase_block_map_and_state_table");
        $finish;
    end

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_LOGICAL;
        cfg_data  <= '0;
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        for (int i = 0; i < MAX_LOGICAL_BLOCKS; i++) map_model[i] = BLK_NONE;
        for (int i = 0; i < MAX_PHYSICAL_BLOCKS; i++) state_model[i] = ST_FREE;
        logical_count = LOGICAL_CAP;
        physical_count = PHYSICAL_CAP;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset contents, extremes, negative indexes, the unused command
        add_row(CMD_READ_MAP,   0,    11'd0,    0,    1, BLK_NONE, 0, 0);
        add_row(CMD_READ_MAP,   1023, 11'd0,    0,    1, BLK_NONE, 0, 0);
        add_row(CMD_WRITE_MAP,  1023, 11'd1023, 0,    1, BLK_NONE, 0, 0);
        add_row(CMD_READ_MAP,   1023, 11'd0,    0,    1, 11'd1023, 0, 0);
        add_row(CMD_WRITE_MAP,  0,    11'h400,  0,    1, BLK_NONE, 0, 0);
        add_row(CMD_READ_MAP,   0,    11'd0,    0,    0, '0, 0, 0);
        add_row(CMD_QUERY_FREE, 0,    11'd0,    0,    1, BLK_NONE, 1, 0);
        add_row(CMD_QUERY_FREE, 0,    11'd1023, 0,    1, BLK_NONE, 1, 0);
        add_row(CMD_QUERY_FREE, 0,    BLK_NONE, 0,    1, BLK_NONE, 0, 1);
        add_row(CMD_QUERY_FREE, 0,    11'h400,  0,    1, BLK_NONE, 0, 1);
        add_row(CMD_MARK_USED,  0,    11'd0,    0,    1, BLK_NONE, 0, 0);
        add_row(CMD_MARK_BAD,   0,    11'd1,    0,    1, BLK_NONE, 0, 0);
        add_row(CMD_QUERY_FREE, 0,    11'd0,    0,    0, '0, 0, 0);
        add_row(CMD_FIND_FREE,  0,    11'd0,    0,    1, BLK_NONE, 0, 0);
        add_row(CMD_FIND_FREE,  0,    11'd0,    2,    0, '0, 0, 0);
        add_row(CMD_FIND_FREE,  0,    11'd0,    1024, 0, '0, 0, 0);
        add_row(CMD_MARK_FREE,  0,    11'd0,    0,    0, '0, 0, 0);
        add_row(CMD_FIND_FREE,  0,    11'd0,    1024, 0, '0, 0, 0);
        add_row(CMD_MARK_BAD,   0,    11'd1023, 0,    0, '0, 0, 0);
        add_row(CMD_QUERY_FREE, 0,    11'd1023, 0,    0, '0, 0, 0);
        add_row(CMD_MARK_USED,  0,    BLK_NONE, 0,    1, BLK_NONE, 0, 1);
        add_row(CMD_MARK_BAD,   0,    11'h5A5,  0,    1, BLK_NONE, 0, 1);
        add_row(CMD_UNUSED,     1023, BLK_NONE, 1024, 1, BLK_NONE, 0, 0);
        add_row(CMD_WRITE_MAP,  5,    BLK_NONE, 0,    0, '0, 0, 0);
        add_row(CMD_READ_MAP,   5,    11'd0,    0,    0, '0, 0, 0);
        foreach (directed_rows[i])
            send_command(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
        wait_drained();

        // full counts, sweep the state store from block 0
        set_block_counts(LOGICAL_CAP, PHYSICAL_CAP);
        run_items(140, 1'b1);
        wait_drained();

        // counts of one, no idling on either side
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        set_block_counts(11'd1, 11'd1);
        run_items(40, 1'b0);
        wait_drained();

        // zero counts: every index out of range
        tx_idle = 1'b1;
        set_block_counts(11'd0, 11'd0);
        run_items(25, 1'b0);
        wait_drained();

        // counts above capacity; hold the result side so the block backs up
        tx_idle = 1'b0;
        rx_idle = 1'b1;
        set_block_counts(11'd2047, 11'd1500);
        rx_hold_cycles = 400;
        run_items(80, 1'b0);
        wait_drained();

        // small counts, search limits mostly beyond the physical count
        tx_idle = 1'b1;
        set_block_counts(11'd17, 11'd100);
        run_items(60, 1'b0);
        wait_drained();

        for (int k = 0; k < 5; k++) begin
            tx_idle = k[0];
            rx_idle = !k[0];
            set_block_counts(CNT_W'($urandom_range(1, 1024)), CNT_W'($urandom_range(1, 1024)));
            run_items(15, k == 2);
            wait_drained();
        end

        repeat (40) @(posedge aclk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("PASS erase_block_map_and_state_table");
        else
            $display("FAIL erase_block_map_and_state_table");
        $finish;
    end

endmodule
